// File: hdl/rrqs_pkg.sv
// shared types and codes for the round-robin quantum scheduler
`timescale 1ns / 1ps
`default_nettype none
package rrqs_pkg;

	localparam int ID_W     = 6;
	localparam int TIME_W   = 32;
	localparam int REQ_W    = 3;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 1;

	typedef logic [REQ_W-1:0]    req_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [ID_W-1:0]     tid_t;
	typedef logic [TIME_W-1:0]   ticks_t;

	localparam req_t REQ_ENQUEUE = 3'd0;
	localparam req_t REQ_DEQUEUE = 3'd1;
	localparam req_t REQ_RUN     = 3'd2;
	localparam req_t REQ_CLEAR   = 3'd3;
	localparam req_t REQ_COPY    = 3'd4;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEND    = 1'b1;

	typedef struct packed {
		status_t status;
		tid_t    next;
	} q_result_t;

endpackage
`default_nettype wire

// File: hdl/round_robin_quantum_scheduler.sv
// top level: round-robin scheduler with time quantum and ready deque
// result_valid follows start via valid_s1; one item per cycle while not busy
// the used-slice table read is registered, writes are forwarded to the next item
// reset: busy is high while the used-slice table is zeroed
// config writes are taken every cycle; results cannot be stalled
`timescale 1ns / 1ps
`default_nettype none
module round_robin_quantum_scheduler
	import rrqs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_THREADS = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [REQ_W-1:0]     req_type,
	input  wire logic [ID_W-1:0]      thread_id,
	input  wire logic [ID_W-1:0]      source_thread_id,
	input  wire logic                 lost_cpu,
	input  wire logic [TIME_W-1:0]    remaining_time,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TIME_W-1:0]    cfg_data,
	output logic                      result_valid,
	output logic [STATUS_W-1:0]       status,
	output logic [ID_W-1:0]           next_thread,
	output logic [TIME_W-1:0]         slice_time,
	output logic [TIME_W-1:0]         time_left,
	output logic                      action_done
);

	localparam int TW = $clog2(MAX_THREADS);

	function automatic logic [TW-1:0] tid_index(input tid_t id);
		logic [ID_W:0] v;
		int            m;
		v = {1'b0, id};
		for (int k = ID_W - 1; k >= 0; k--) begin
			m = MAX_THREADS << k;
			if (m < (1 << ID_W) && int'(v) >= m) begin
				v = v - (ID_W + 1)'(m);
			end
		end
		return TW'(v);
	endfunction

	ticks_t        quantum_q;
	logic          send_q;
	logic          accept;
	logic          clearing;
	logic [TW-1:0] rd_addr;

	logic          valid_s1;
	req_t          req_s1;
	logic [TW-1:0] tid_s1;
	logic          lost_s1;
	ticks_t        rem_s1;

	q_result_t     qres_s1;
	ticks_t        used_s1;
	ticks_t        slice;
	ticks_t        left;
	logic          done;
	ticks_t        new_used;
	logic          is_run;
	logic          wr_en;
	ticks_t        wr_data;

	assign busy      = clearing;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign rd_addr   = (req_type == REQ_COPY) ? tid_index(source_thread_id)
		: tid_index(thread_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= '0;
			send_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_QUANTUM: quantum_q <= cfg_data;
				CFG_SEND:    send_q    <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			req_s1   <= REQ_ENQUEUE;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				req_s1 <= req_type;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tid_s1  <= tid_index(thread_id);
			lost_s1 <= lost_cpu;
			rem_s1  <= remaining_time;
		end
	end

	rrqs_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.req           (req_type),
		.thread_id     (thread_id),
		.lost_cpu      (lost_cpu),
		.send_loses_cpu(send_q),
		.res_s1        (qres_s1)
	);

	rrqs_slice_calc u_calc (
		.used     (used_s1),
		.quantum  (quantum_q),
		.remaining(rem_s1),
		.lost_cpu (lost_s1),
		.slice    (slice),
		.left     (left),
		.done     (done),
		.new_used (new_used)
	);

	assign is_run = (req_s1 == REQ_RUN);

	always_comb begin
		wr_en   = 1'b0;
		wr_data = '0;
		case (req_s1)
			REQ_RUN: begin
				wr_en   = valid_s1;
				wr_data = new_used;
			end
			REQ_CLEAR: begin
				wr_en   = valid_s1;
				wr_data = '0;
			end
			REQ_COPY: begin
				wr_en   = valid_s1;
				wr_data = used_s1;
			end
			default: begin
				wr_en   = 1'b0;
				wr_data = '0;
			end
		endcase
	end

	rrqs_used_table #(
		.MAX_THREADS(MAX_THREADS)
	) u_used (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (tid_s1),
		.wr_data (wr_data),
		.used_s1 (used_s1),
		.clearing(clearing)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status      <= qres_s1.status;
			next_thread <= qres_s1.next;
			slice_time  <= is_run ? slice : '0;
			time_left   <= is_run ? left : '0;
			action_done <= is_run && done;
		end
	end

endmodule
`default_nettype wire

// File: hdl/rrqs_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module rrqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: hdl/rrqs_queue.sv
// ready deque: head pointer, fill count, id storage and enqueue/dequeue status
`timescale 1ns / 1ps
`default_nettype none
module rrqs_queue
	import rrqs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      accept,
	input  wire req_t      req,
	input  wire tid_t      thread_id,
	input  wire logic      lost_cpu,
	input  wire logic      send_loses_cpu,
	output q_result_t      res_s1
);

	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = QW + 2;

	logic [QW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic          full;
	logic          empty;
	logic          enq;
	logic          deq;
	logic          to_tail;
	logic [QW-1:0] head_inc;
	logic [QW-1:0] head_dec;
	logic [SW-1:0] tail_sum;
	logic [QW-1:0] tail;
	logic          we;
	logic [QW-1:0] waddr;
	tid_t          rdata;
	status_t       status_s1;
	logic          deq_ok_s1;

	assign full    = (count_q == CW'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign enq     = accept && (req == REQ_ENQUEUE) && !full;
	assign deq     = accept && (req == REQ_DEQUEUE) && !empty;
	assign to_tail = lost_cpu || send_loses_cpu;

	assign head_inc = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QW'(1);
	assign head_dec = (head_q == '0) ? QW'(QUEUE_DEPTH - 1) : head_q - QW'(1);
	assign tail_sum = SW'(head_q) + SW'(count_q);
	assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? QW'(tail_sum - SW'(QUEUE_DEPTH))
		: QW'(tail_sum);

	assign we    = enq;
	assign waddr = to_tail ? tail : head_dec;

	rrqs_ram #(
		.WIDTH(ID_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ids (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(thread_id),
		.raddr(head_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			count_q   <= '0;
			status_s1 <= ST_OK;
			deq_ok_s1 <= 1'b0;
		end else begin
			if (enq) begin
				count_q <= count_q + CW'(1);
				if (!to_tail) begin
					head_q <= head_dec;
				end
			end else if (deq) begin
				count_q <= count_q - CW'(1);
				head_q  <= head_inc;
			end
			if (accept) begin
				deq_ok_s1 <= deq;
				if (req == REQ_ENQUEUE && full) begin
					status_s1 <= ST_FULL;
				end else if (req == REQ_DEQUEUE && empty) begin
					status_s1 <= ST_EMPTY;
				end else begin
					status_s1 <= ST_OK;
				end
			end
		end
	end

	assign res_s1.status = status_s1;
	assign res_s1.next   = deq_ok_s1 ? rdata : '0;

endmodule
`default_nettype wire

// File: hdl/rrqs_used_table.sv
// per-thread used-slice table with clearing pass after reset and write bypass
`timescale 1ns / 1ps
`default_nettype none
module rrqs_used_table
	import rrqs_pkg::*;
#(
	parameter int MAX_THREADS = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire logic [$clog2(MAX_THREADS)-1:0] rd_addr,
	input  wire logic                           wr_en,
	input  wire logic [$clog2(MAX_THREADS)-1:0] wr_addr,
	input  wire ticks_t                         wr_data,
	output ticks_t                              used_s1,
	output logic                                clearing
);

	localparam int TW = $clog2(MAX_THREADS);

	logic          clear_q;
	logic [TW-1:0] clr_addr_q;
	logic          byp_q;
	ticks_t        byp_data_q;
	logic          we;
	logic [TW-1:0] waddr;
	ticks_t        wdata;
	ticks_t        rdata;

	assign we    = clear_q || wr_en;
	assign waddr = clear_q ? clr_addr_q : wr_addr;
	assign wdata = clear_q ? '0 : wr_data;

	rrqs_ram #(
		.WIDTH(TIME_W),
		.DEPTH(MAX_THREADS)
	) u_used (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
			byp_q      <= 1'b0;
		end else begin
			if (clear_q) begin
				clr_addr_q <= clr_addr_q + TW'(1);
				if (clr_addr_q == TW'(MAX_THREADS - 1)) begin
					clear_q <= 1'b0;
				end
			end
			if (accept) begin
				byp_q <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byp_data_q <= wr_data;
		end
	end

	assign used_s1  = byp_q ? byp_data_q : rdata;
	assign clearing = clear_q;

endmodule
`default_nettype wire

// File: hdl/rrqs_slice_calc.sv
// quantum grant arithmetic for a run request
`timescale 1ns / 1ps
`default_nettype none
module rrqs_slice_calc
	import rrqs_pkg::*;
(
	input  wire ticks_t used,
	input  wire ticks_t quantum,
	input  wire ticks_t remaining,
	input  wire logic   lost_cpu,
	output ticks_t      slice,
	output ticks_t      left,
	output logic        done,
	output ticks_t      new_used
);

	logic   fresh;
	ticks_t avail;
	ticks_t fresh_slice;
	ticks_t cont_slice;

	assign fresh       = lost_cpu || (used == quantum);
	assign avail       = (quantum > used) ? quantum - used : '0;
	assign fresh_slice = (remaining < quantum) ? remaining : quantum;
	assign cont_slice  = (avail < remaining) ? avail : remaining;
	assign slice       = fresh ? fresh_slice : cont_slice;
	assign new_used    = fresh ? fresh_slice : used + cont_slice;
	assign left        = remaining - slice;
	assign done        = (left == '0);

endmodule
`default_nettype wire

// File: dv/tb.sv
// testbench for the round-robin quantum scheduler: directed and random requests against a predictor
`timescale 1ns / 1ps
module tb;
	import rrqs_pkg::*;

	localparam int QDEPTH      = 16;
	localparam int NTHREADS    = 64;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int N_PHASES    = 6;
	localparam int PHASE_ITEMS = 140;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_CAP   = 40;

	typedef struct packed {
		status_t st;
		tid_t    nxt;
		ticks_t  slice;
		ticks_t  left;
		logic    done;
	} sched_reply_t;

	class sched_scoreboard;
		tid_t              ready_slot[QDEPTH];
		logic [QPTR_W-1:0] head;
		logic [QPTR_W:0]   queued;
		ticks_t            used_ticks[NTHREADS];
		ticks_t            quantum;
		logic              tail_always;
		sched_reply_t      expected_replies[$];
		int                errors;
		int                n_req[8];
		int                n_full;
		int                n_empty;
		int                n_checked;
		int                n_cfg;

		function new();
			foreach (ready_slot[i]) ready_slot[i] = '0;
			foreach (used_ticks[i]) used_ticks[i] = '0;
			foreach (n_req[i]) n_req[i] = 0;
			head = '0;
			queued = '0;
			quantum = '0;
			tail_always = 1'b0;
			errors = 0;
			n_full = 0;
			n_empty = 0;
			n_checked = 0;
			n_cfg = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, ticks_t data);
			if (idx == CFG_QUANTUM) begin
				quantum = data;
			end else if (idx == CFG_SEND) begin
				tail_always = data[0];
			end
			n_cfg++;
		endfunction

		function void predict_request(req_t req, tid_t tid, tid_t src, logic lost, ticks_t rem);
			sched_reply_t      r;
			ticks_t            u;
			ticks_t            avail;
			logic [QPTR_W-1:0] slot;
			r = '0;
			n_req[req]++;
			case (req)
				REQ_ENQUEUE: begin
					if (queued >= QDEPTH) begin
						r.st = ST_FULL;
						n_full++;
					end else if (lost || tail_always) begin
						slot = head + queued[QPTR_W-1:0];
						ready_slot[slot] = tid;
						queued++;
					end else begin
						head = head - 1'b1;
						ready_slot[head] = tid;
						queued++;
					end
				end
				REQ_DEQUEUE: begin
					if (queued == 0) begin
						r.st = ST_EMPTY;
						n_empty++;
					end else begin
						r.nxt = ready_slot[head];
						head = head + 1'b1;
						queued--;
					end
				end
				REQ_RUN: begin
					u = used_ticks[tid];
					if (lost || u == quantum) begin
						r.slice = (rem < quantum) ? rem : quantum;
						used_ticks[tid] = r.slice;
					end else begin
						avail = (quantum > u) ? quantum - u : '0;
						r.slice = (avail < rem) ? avail : rem;
						used_ticks[tid] = u + r.slice;
					end
					r.left = rem - r.slice;
					r.done = (r.left == 0);
				end
				REQ_CLEAR: used_ticks[tid] = '0;
				REQ_COPY:  used_ticks[tid] = used_ticks[src];
				default: ;
			endcase
			expected_replies.push_back(r);
		endfunction

		task report(string what);
			errors++;
			if (errors <= PRINT_CAP)
				$display("MISMATCH at %0t: %s", $time, what);
		endtask

		task check_reply(status_t st, tid_t nxt, ticks_t slice, ticks_t left, logic done);
			sched_reply_t e;
			n_checked++;
			if (expected_replies.size() == 0) begin
				report("result strobe with no request outstanding");
			end else begin
				e = expected_replies.pop_front();
				if (st !== e.st)
					report($sformatf("status got %0d expected %0d", st, e.st));
				if (nxt !== e.nxt)
					report($sformatf("next_thread got %0d expected %0d", nxt, e.nxt));
				if (slice !== e.slice)
					report($sformatf("slice_time got %0d expected %0d", slice, e.slice));
				if (left !== e.left)
					report($sformatf("time_left got %0d expected %0d", left, e.left));
				if (done !== e.done)
					report($sformatf("action_done got %0b expected %0b", done, e.done));
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	req_t                 req_type = '0;
	tid_t                 thread_id = '0;
	tid_t                 source_thread_id = '0;
	logic                 lost_cpu = 1'b0;
	ticks_t               remaining_time = '0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	ticks_t               cfg_data = '0;
	logic                 result_valid;
	status_t              status;
	tid_t                 next_thread;
	ticks_t               slice_time;
	ticks_t               time_left;
	logic                 action_done;

	sched_scoreboard sb = new();
	int              gap_pct = 23;
	int              cycles = 0;

	round_robin_quantum_scheduler #(
		.QUEUE_DEPTH(QDEPTH),
		.MAX_THREADS(NTHREADS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.thread_id(thread_id),
		.source_thread_id(source_thread_id),
		.lost_cpu(lost_cpu),
		.remaining_time(remaining_time),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.status(status),
		.next_thread(next_thread),
		.slice_time(slice_time),
		.time_left(time_left),
		.action_done(action_done)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				sb.check_reply(status, next_thread, slice_time, time_left, action_done);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (start && !busy)
				sb.predict_request(req_type, thread_id, source_thread_id, lost_cpu,
					remaining_time);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_req(req_t r, tid_t t, tid_t s, logic l, ticks_t rem);
		while ($urandom_range(99) < gap_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		req_type = r;
		thread_id = t;
		source_thread_id = s;
		lost_cpu = l;
		remaining_time = rem;
		start = 1'b1;
		while (busy) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, ticks_t data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_replies();
		start = 1'b0;
		while (sb.expected_replies.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic tid_t pick_tid();
		return ($urandom_range(99) < 70) ? tid_t'($urandom_range(7)) : tid_t'($urandom_range(63));
	endfunction

	function automatic ticks_t pick_time(ticks_t q);
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2, 3:    return ticks_t'($urandom);
			4, 5:    return q - ticks_t'($urandom_range(3));
			6:       return q + ticks_t'($urandom_range(3));
			default: return ticks_t'($urandom_range(1, 40));
		endcase
	endfunction

	task automatic rand_req(int mode);
		int   r;
		int   enq_w;
		int   deq_w;
		int   base;
		req_t req;
		r = $urandom_range(99);
		enq_w = (mode == 0) ? 40 : (mode == 1) ? 15 : 25;
		deq_w = (mode == 0) ? 15 : (mode == 1) ? 40 : 25;
		base = enq_w + deq_w + 25;
		if (r < enq_w)
			req = REQ_ENQUEUE;
		else if (r < enq_w + deq_w)
			req = REQ_DEQUEUE;
		else if (r < base)
			req = REQ_RUN;
		else if (r < base + 7)
			req = REQ_CLEAR;
		else if (r < base + 14)
			req = REQ_COPY;
		else
			req = req_t'($urandom_range(int'(REQ_COPY) + 1, (1 << REQ_W) - 1));
		send_req(req, pick_tid(), pick_tid(), $urandom_range(99) < 25, pick_time(sb.quantum));
	endtask

	initial begin
		ticks_t q_plan[N_PHASES];
		logic   send_plan[N_PHASES];
		int     mode;
		q_plan = '{32'd1000, 32'd10, 32'd0, 32'hFFFF_FFFF, ticks_t'($urandom), 32'd1};
		send_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom_range(1)), 1'b0};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		while (busy) @(negedge clk);

		write_cfg(CFG_QUANTUM, 32'd100);
		write_cfg(CFG_SEND, 32'd0);
		cfg_valid = 1'b0;

		send_req(REQ_DEQUEUE, '0, '0, 1'b0, '0);
		send_req(REQ_RUN, 6'd3, '0, 1'b0, '0);
		send_req(REQ_RUN, 6'd3, '0, 1'b0, 32'd30);
		send_req(REQ_RUN, 6'd3, '0, 1'b0, 32'd200);
		send_req(REQ_RUN, 6'd3, '0, 1'b0, 32'd50);
		send_req(REQ_RUN, '1, '0, 1'b1, '1);
		send_req(REQ_COPY, 6'd5, '1, 1'b0, '0);
		send_req(REQ_CLEAR, '1, '0, 1'b0, '0);
		send_req(req_t'((1 << REQ_W) - 1), '1, '1, 1'b1, '1);
		for (int i = 0; i <= QDEPTH; i++)
			send_req(REQ_ENQUEUE, tid_t'(i * 4), '0, 1'(i), '0);

		for (int p = 0; p < N_PHASES; p++) begin
			drain_replies();
			write_cfg(CFG_QUANTUM, q_plan[p]);
			write_cfg(CFG_SEND, ticks_t'(send_plan[p]));
			cfg_valid = 1'b0;
			gap_pct = (p == 3) ? 0 : 23;
			mode = 2;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 24 == 0)
					mode = $urandom_range(2);
				rand_req(mode);
			end
		end

		drain_replies();
		$display("covered %0d enqueue, %0d dequeue, %0d run, %0d clear, %0d copy requests, %0d results",
			sb.n_req[REQ_ENQUEUE], sb.n_req[REQ_DEQUEUE], sb.n_req[REQ_RUN],
			sb.n_req[REQ_CLEAR], sb.n_req[REQ_COPY], sb.n_checked);
		$display("queue full %0d times, queue empty %0d times, %0d register writes, %0d mismatches",
			sb.n_full, sb.n_empty, sb.n_cfg, sb.errors);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
